// File: sv/rrhh_pkg.sv
// Shared types, widths and constants of the random-read heterozygosity histogram.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rrhh_pkg;

    localparam int DEPTH_BINS_DEF = 1024;

    localparam int DEPTH_W    = 20;
    localparam int DP_W       = DEPTH_W + 1;
    localparam int BASE_W     = 3;
    localparam int BIN_IDX_W  = 10;
    localparam int CNT_W      = 32;
    localparam int GEN_W      = 48;
    localparam int DRAW_W     = 31;
    localparam int CHUNK_W    = 16;
    localparam int MUL_W      = 35;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;

    localparam logic [MUL_W-1:0] LCG_MUL    = 35'h5DEECE66D;
    localparam logic [GEN_W-1:0] LCG_ADD    = 48'hB;
    localparam logic [GEN_W-1:0] SEED_RESET = 48'd253405757471;

    localparam logic [BASE_W-1:0] BASE_A = 3'd0;
    localparam logic [BASE_W-1:0] BASE_C = 3'd1;
    localparam logic [BASE_W-1:0] BASE_G = 3'd2;
    localparam logic [BASE_W-1:0] BASE_T = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SKIP_TRANS = 1'b0,
        CFG_SEED       = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_SITE = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_COUNTED    = 2'd0,
        ST_ZERO_DEPTH = 2'd1,
        ST_TRANS_SKIP = 2'd2,
        ST_TOO_DEEP   = 2'd3
    } site_status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_GEN_GO,
        S_GEN_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_MEM_RD,
        S_MEM_WR,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic gen_start;
        logic div_start;
        logic take_draw;
        logic mem_rd;
        logic mem_wr;
        logic out_load;
    } rrhh_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_read;
        logic zero_depth;
        logic trans_skip;
        logic dp_fits;
        logic gen_done;
        logic div_done;
        logic second_draw;
        logic out_free;
    } rrhh_stat_t;

    function automatic logic is_transition(input logic [BASE_W-1:0] rb,
                                           input logic [BASE_W-1:0] ab);
        return (rb == BASE_C && ab == BASE_T) || (rb == BASE_T && ab == BASE_C) ||
               (rb == BASE_G && ab == BASE_A) || (rb == BASE_A && ab == BASE_G);
    endfunction

endpackage

`default_nettype wire

// File: sv/rrhh_lcg.sv
// 48-bit linear congruential generator with a 16-bit-slice multiply.
// Depends on rrhh_pkg.
`default_nettype none

module rrhh_lcg (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        seed_load,
    input  wire logic [rrhh_pkg::GEN_W-1:0]  seed,
    input  wire logic                        start,
    output logic                             done,
    output logic      [rrhh_pkg::DRAW_W-1:0] draw
);
    import rrhh_pkg::*;

    localparam int PROD_W = CHUNK_W + MUL_W;

    logic [GEN_W-1:0]   state_reg;
    logic [GEN_W-1:0]   acc_reg;
    logic [GEN_W-1:0]   prod_reg;
    logic [1:0]         step_reg;
    logic               busy_reg;
    logic [CHUNK_W-1:0] chunk;
    logic [PROD_W-1:0]  prod_full;
    logic [GEN_W-1:0]   shifted;
    logic [GEN_W-1:0]   acc_sum;

    always_comb begin
        unique case (step_reg)
            2'd0: chunk = state_reg[15:0];
            2'd1: chunk = state_reg[31:16];
            2'd2: chunk = state_reg[47:32];
            default: chunk = '0;
        endcase
        unique case (step_reg)
            2'd1: shifted = prod_reg;
            2'd2: shifted = prod_reg << CHUNK_W;
            2'd3: shifted = prod_reg << (2 * CHUNK_W);
            default: shifted = '0;
        endcase
        prod_full = {{MUL_W{1'b0}}, chunk} * {{CHUNK_W{1'b0}}, LCG_MUL};
        acc_sum   = acc_reg + shifted;
    end

    assign done = busy_reg && (step_reg == 2'd3);
    assign draw = state_reg[GEN_W-1:GEN_W-DRAW_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEED_RESET;
            busy_reg  <= 1'b0;
            step_reg  <= '0;
        end else begin
            if (seed_load) begin
                state_reg <= seed;
            end else if (done) begin
                state_reg <= acc_sum;
            end
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= LCG_ADD;
        end else if (busy_reg) begin
            acc_reg  <= acc_sum;
            prod_reg <= prod_full[GEN_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: sv/rrhh_div.sv
// Remainder unit: restoring division, two quotient bits per cycle.
// Depends on rrhh_pkg.
`default_nettype none

module rrhh_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [rrhh_pkg::DRAW_W-1:0] dividend,
    input  wire logic [rrhh_pkg::DP_W-1:0]   divisor,
    output logic                             done,
    output logic      [rrhh_pkg::DP_W-1:0]   remainder
);
    import rrhh_pkg::*;

    localparam int DVD_W  = DRAW_W + 1;
    localparam int STEPS  = DVD_W / 2;
    localparam int STEP_W = $clog2(STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    logic [DVD_W-1:0]  dvd_reg;
    logic [DP_W-1:0]   rem_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DP_W-1:0]   rem_one;
    logic [DP_W-1:0]   rem_two;

    function automatic logic [DP_W-1:0] rem_step(input logic [DP_W-1:0] r,
                                                 input logic b,
                                                 input logic [DP_W-1:0] d);
        logic [DP_W:0] t;
        t = {r, b};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
        end
        return t[DP_W-1:0];
    endfunction

    always_comb begin
        rem_one = rem_step(rem_reg, dvd_reg[DVD_W-1], divisor);
        rem_two = rem_step(rem_one, dvd_reg[DVD_W-2], divisor);
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == LAST_STEP);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + STEP_W'(1);
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= {1'b0, dividend};
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << 2;
            rem_reg <= rem_two;
        end
    end

endmodule

`default_nettype wire

// File: sv/rrhh_datapath.sv
// Datapath: input capture, configuration, generator, remainder unit, count memories
// and the result register. Depends on rrhh_pkg, rrhh_lcg and rrhh_div.
`default_nettype none

module rrhh_datapath #(
    parameter int DEPTH_BINS = rrhh_pkg::DEPTH_BINS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [rrhh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rrhh_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            s_operation,
    input  wire logic [rrhh_pkg::DEPTH_W-1:0]    s_ref_depth,
    input  wire logic [rrhh_pkg::DEPTH_W-1:0]    s_alt_depth,
    input  wire logic [rrhh_pkg::BASE_W-1:0]     s_ref_base,
    input  wire logic [rrhh_pkg::BASE_W-1:0]     s_alt_base,
    input  wire logic [rrhh_pkg::BIN_IDX_W-1:0]  s_bin_index,
    input  wire rrhh_pkg::rrhh_cmd_t             cmd,
    output rrhh_pkg::rrhh_stat_t                 stat,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [1:0]                      m_site_status,
    output logic                                 m_is_het,
    output logic      [rrhh_pkg::CNT_W-1:0]      m_bin_sites,
    output logic      [rrhh_pkg::CNT_W-1:0]      m_bin_hets
);
    import rrhh_pkg::*;

    localparam int BIN_W = $clog2(DEPTH_BINS);
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(DEPTH_BINS - 1);
    localparam logic [31:0]      BINS_32  = 32'(DEPTH_BINS);

    logic                 skip_reg;
    op_t                  op_reg;
    logic [DEPTH_W-1:0]   dref_reg;
    logic [DP_W-1:0]      dp_reg;
    logic [BIN_IDX_W-1:0] bin_reg;
    logic                 zero_reg;
    logic                 trans_reg;
    logic                 g0_reg;
    logic                 g1_reg;
    logic                 second_reg;
    logic [BIN_W-1:0]     clr_addr_reg;
    logic [CNT_W-1:0]     site_rd_reg;
    logic [CNT_W-1:0]     het_rd_reg;
    logic                 m_valid_reg;
    site_status_t         status_reg;
    logic                 het_out_reg;
    logic [CNT_W-1:0]     sites_out_reg;
    logic [CNT_W-1:0]     hets_out_reg;

    logic [CNT_W-1:0] site_mem [DEPTH_BINS];
    logic [CNT_W-1:0] het_mem  [DEPTH_BINS];

    logic [DP_W-1:0]   dp_sum;
    logic [31:0]       bin_wide;
    logic [31:0]       dp_wide;
    logic              bin_ok;
    logic              dp_fits;
    logic [BIN_W-1:0]  bin_addr;
    logic [BIN_W-1:0]  dp_addr;
    logic [BIN_W-1:0]  rd_addr;
    logic              wr_en;
    logic [BIN_W-1:0]  wr_addr;
    logic [CNT_W-1:0]  wr_site;
    logic [CNT_W-1:0]  wr_het;
    logic              het_pair;
    logic              gen_done;
    logic [DRAW_W-1:0] draw;
    logic              div_done;
    logic [DP_W-1:0]   remainder;
    logic              g_now;
    logic              out_free;
    site_status_t      status_now;
    logic              het_now;
    logic [CNT_W-1:0]  sites_now;
    logic [CNT_W-1:0]  hets_now;

    rrhh_lcg u_lcg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .seed_load (cfg_we && (cfg_index == CFG_SEED)),
        .seed      (cfg_data[GEN_W-1:0]),
        .start     (cmd.gen_start),
        .done      (gen_done),
        .draw      (draw)
    );

    rrhh_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (draw),
        .divisor   (dp_reg),
        .done      (div_done),
        .remainder (remainder)
    );

    always_comb begin
        dp_sum   = {1'b0, s_ref_depth} + {1'b0, s_alt_depth};
        bin_wide = 32'(bin_reg);
        dp_wide  = 32'(dp_reg);
        bin_ok   = bin_wide < BINS_32;
        dp_fits  = dp_wide < BINS_32;
        bin_addr = bin_wide[BIN_W-1:0];
        dp_addr  = dp_wide[BIN_W-1:0];
        rd_addr  = (op_reg == OP_READ) ? bin_addr : dp_addr;
        g_now    = remainder < {1'b0, dref_reg};
        het_pair = g0_reg ^ g1_reg;
        out_free = !m_valid_reg || m_ready;

        wr_en   = cmd.clear || cmd.mem_wr;
        wr_addr = cmd.clear ? clr_addr_reg : dp_addr;
        if (cmd.clear) begin
            wr_site = '0;
            wr_het  = '0;
        end else begin
            wr_site = (site_rd_reg == '1) ? site_rd_reg : site_rd_reg + CNT_W'(1);
            wr_het  = (het_pair && het_rd_reg != '1) ? het_rd_reg + CNT_W'(1) : het_rd_reg;
        end

        sites_now = '0;
        hets_now  = '0;
        het_now   = 1'b0;
        priority if (op_reg == OP_READ) begin
            status_now = ST_COUNTED;
            if (bin_ok) begin
                sites_now = site_rd_reg;
                hets_now  = het_rd_reg;
            end
        end else if (zero_reg) begin
            status_now = ST_ZERO_DEPTH;
        end else if (trans_reg) begin
            status_now = ST_TRANS_SKIP;
        end else begin
            het_now    = het_pair;
            status_now = dp_fits ? ST_COUNTED : ST_TOO_DEEP;
        end
    end

    always_comb begin
        stat.clr_last    = clr_addr_reg == LAST_BIN;
        stat.is_read     = op_reg == OP_READ;
        stat.zero_depth  = zero_reg;
        stat.trans_skip  = trans_reg;
        stat.dp_fits     = dp_fits;
        stat.gen_done    = gen_done;
        stat.div_done    = div_done;
        stat.second_draw = second_reg;
        stat.out_free    = out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg     <= 1'b0;
            second_reg   <= 1'b0;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == CFG_SKIP_TRANS) begin
                skip_reg <= cfg_data[0];
            end
            if (cmd.capture) begin
                second_reg <= 1'b0;
            end else if (cmd.take_draw) begin
                second_reg <= !second_reg;
            end
            if (cmd.clear) begin
                clr_addr_reg <= clr_addr_reg + BIN_W'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= op_t'(s_operation);
            dref_reg  <= s_ref_depth;
            dp_reg    <= dp_sum;
            bin_reg   <= s_bin_index;
            zero_reg  <= dp_sum == '0;
            trans_reg <= skip_reg && is_transition(s_ref_base, s_alt_base);
        end
        if (cmd.take_draw) begin
            if (second_reg) begin
                g1_reg <= g_now;
            end else begin
                g0_reg <= g_now;
            end
        end
        if (cmd.out_load) begin
            status_reg    <= status_now;
            het_out_reg   <= het_now;
            sites_out_reg <= sites_now;
            hets_out_reg  <= hets_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            site_mem[wr_addr] <= wr_site;
            het_mem[wr_addr]  <= wr_het;
        end
        if (cmd.mem_rd) begin
            site_rd_reg <= site_mem[rd_addr];
            het_rd_reg  <= het_mem[rd_addr];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_site_status = status_reg;
    assign m_is_het      = het_out_reg;
    assign m_bin_sites   = sites_out_reg;
    assign m_bin_hets    = hets_out_reg;

endmodule

`default_nettype wire

// File: sv/rrhh_ctrl.sv
// Controller state machine that sequences clearing, sampling and count updates.
// Depends on rrhh_pkg.
`default_nettype none

module rrhh_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire rrhh_pkg::rrhh_stat_t stat,
    output rrhh_pkg::rrhh_cmd_t       cmd
);
    import rrhh_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (stat.is_read) begin
                    state_next = S_MEM_RD;
                end else if (stat.zero_depth || stat.trans_skip) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = S_GEN_GO;
                end
            end
            S_GEN_GO: state_next = S_GEN_WAIT;
            S_GEN_WAIT: begin
                if (stat.gen_done) begin
                    state_next = S_DIV_GO;
                end
            end
            S_DIV_GO: state_next = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (stat.div_done) begin
                    priority if (!stat.second_draw) begin
                        state_next = S_GEN_GO;
                    end else if (stat.dp_fits) begin
                        state_next = S_MEM_RD;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_MEM_RD: state_next = stat.is_read ? S_FINISH : S_MEM_WR;
            S_MEM_WR: state_next = S_FINISH;
            S_FINISH: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        s_ready       = state_reg == S_IDLE;
        cmd.clear     = state_reg == S_CLEAR;
        cmd.capture   = (state_reg == S_IDLE) && s_valid;
        cmd.gen_start = state_reg == S_GEN_GO;
        cmd.div_start = state_reg == S_DIV_GO;
        cmd.take_draw = (state_reg == S_DIV_WAIT) && stat.div_done;
        cmd.mem_rd    = state_reg == S_MEM_RD;
        cmd.mem_wr    = state_reg == S_MEM_WR;
        cmd.out_load  = (state_reg == S_FINISH) && stat.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/random_read_het_histogram_top.sv
// Top level of the random-read heterozygosity histogram.
// Depends on rrhh_pkg, rrhh_ctrl and rrhh_datapath.
//
//   Channel   Handshake            Payload
//   config    cfg_we               cfg_index, cfg_data
//   input     s_valid / s_ready    s_operation, s_ref_depth, s_alt_depth, s_ref_base,
//                                  s_alt_base, s_bin_index
//   result    m_valid / m_ready    m_site_status, m_is_het, m_bin_sites, m_bin_hets
//
// A counted site makes two draws, each through the generator and then the divider, and then
// reads and writes its count memories; a site too deep to count makes the draws but no memory
// access; a read word reads the memories once, and a dropped site makes neither.
// After reset the count memories are cleared bin by bin with s_ready low.
// A finished word waits in the result register while a new word is accepted; the next one
// stalls in its last cycle until that word is taken.
`default_nettype none

module random_read_het_histogram_top #(
    parameter int DEPTH_BINS = rrhh_pkg::DEPTH_BINS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [rrhh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rrhh_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_operation,
    input  wire logic [rrhh_pkg::DEPTH_W-1:0]    s_ref_depth,
    input  wire logic [rrhh_pkg::DEPTH_W-1:0]    s_alt_depth,
    input  wire logic [rrhh_pkg::BASE_W-1:0]     s_ref_base,
    input  wire logic [rrhh_pkg::BASE_W-1:0]     s_alt_base,
    input  wire logic [rrhh_pkg::BIN_IDX_W-1:0]  s_bin_index,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [1:0]                      m_site_status,
    output logic                                 m_is_het,
    output logic      [rrhh_pkg::CNT_W-1:0]      m_bin_sites,
    output logic      [rrhh_pkg::CNT_W-1:0]      m_bin_hets
);
    import rrhh_pkg::*;

    rrhh_cmd_t  cmd;
    rrhh_stat_t stat;

    rrhh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rrhh_datapath #(
        .DEPTH_BINS (DEPTH_BINS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_operation   (s_operation),
        .s_ref_depth   (s_ref_depth),
        .s_alt_depth   (s_alt_depth),
        .s_ref_base    (s_ref_base),
        .s_alt_base    (s_alt_base),
        .s_bin_index   (s_bin_index),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_site_status (m_site_status),
        .m_is_het      (m_is_het),
        .m_bin_sites   (m_bin_sites),
        .m_bin_hets    (m_bin_hets)
    );

endmodule

`default_nettype wire

// File: sv/rrhh_checker.sv
// Port-level checks of the histogram top level, bound to it below.
// Depends on rrhh_pkg and random_read_het_histogram_top.
`default_nettype none

module rrhh_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_valid,
    input wire logic                       s_ready,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic [1:0]                 m_site_status,
    input wire logic                       m_is_het,
    input wire logic [rrhh_pkg::CNT_W-1:0] m_bin_sites,
    input wire logic [rrhh_pkg::CNT_W-1:0] m_bin_hets
);
    import rrhh_pkg::*;

    // Reset starts the clearing pass and empties the result register.
    assert property (@(posedge aclk) !aresetn |=> !m_valid && !s_ready)
        else $error("reset did not empty the result register or hold off input");

    // One word is worked on at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a word is still in progress");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_site_status) && $stable(m_is_het)
            && $stable(m_bin_sites) && $stable(m_bin_hets))
        else $error("stalled result word changed");

    // Dropped sites make no draws.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_site_status == ST_ZERO_DEPTH || m_site_status == ST_TRANS_SKIP)
            |-> !m_is_het)
        else $error("dropped site reports a heterozygous pair");

    // Only a read word carries bin counts.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_site_status != ST_COUNTED |-> m_bin_sites == '0 && m_bin_hets == '0)
        else $error("site word carries bin counts");

endmodule

bind random_read_het_histogram_top rrhh_checker u_rrhh_checker (.*);

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the random-read heterozygosity histogram top level.
// Holds a scoreboard class that predicts every result word; depends on rrhh_pkg and the RTL.
import rrhh_pkg::*;

localparam int BINS = DEPTH_BINS_DEF;
localparam logic [GEN_W-1:0] GEN_MULT = 48'h5DEECE66D;
localparam logic [GEN_W-1:0] GEN_INC = 48'hB;

typedef struct {
    op_t                  op;
    logic [DEPTH_W-1:0]   rdep;
    logic [DEPTH_W-1:0]   adep;
    logic [BASE_W-1:0]    rbase;
    logic [BASE_W-1:0]    abase;
    logic [BIN_IDX_W-1:0] bin;
} word_t;

typedef struct {
    site_status_t     status;
    logic             het;
    logic [CNT_W-1:0] sites;
    logic [CNT_W-1:0] hets;
} result_t;

class histogram_scoreboard;
    bit               skip_trans;
    logic [GEN_W-1:0] gen;
    logic [CNT_W-1:0] site_cnt [BINS];
    logic [CNT_W-1:0] het_cnt [BINS];
    result_t          expected_q [$];
    int               errors;
    int               checked;
    int               reads;
    int               status_seen [4];

    function new();
        skip_trans = 1'b0;
        gen = SEED_RESET;
        for (int i = 0; i < BINS; i++) begin
            site_cnt[i] = '0;
            het_cnt[i] = '0;
        end
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SKIP_TRANS: skip_trans = data[0];
            CFG_SEED: gen = data[GEN_W-1:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function logic [DRAW_W-1:0] next_draw();
        gen = gen * GEN_MULT + GEN_INC;
        return gen[GEN_W-1:GEN_W-DRAW_W];
    endfunction

    function bit transition(logic [BASE_W-1:0] rb, logic [BASE_W-1:0] ab);
        case ({rb, ab})
            {BASE_C, BASE_T}, {BASE_T, BASE_C}, {BASE_G, BASE_A}, {BASE_A, BASE_G}: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v, logic d);
        return (d && v == '1) ? v : v + CNT_W'(d);
    endfunction

    function void note_input(word_t w);
        result_t          r;
        logic [DP_W-1:0]  dp;
        logic [31:0]      v0;
        logic [31:0]      v1;
        logic             g0;
        logic             g1;
        r.status = ST_COUNTED;
        r.het = 1'b0;
        r.sites = '0;
        r.hets = '0;
        if (w.op == OP_READ) begin
            reads++;
            if (w.bin < BINS) begin
                r.sites = site_cnt[w.bin];
                r.hets = het_cnt[w.bin];
            end
        end else begin
            dp = {1'b0, w.rdep} + {1'b0, w.adep};
            if (dp == 0) begin
                r.status = ST_ZERO_DEPTH;
            end else if (skip_trans && transition(w.rbase, w.abase)) begin
                r.status = ST_TRANS_SKIP;
            end else begin
                v0 = {1'b0, next_draw()} % 32'(dp);
                v1 = {1'b0, next_draw()} % 32'(dp);
                g0 = v0 < 32'(w.rdep);
                g1 = v1 < 32'(w.rdep);
                r.het = g0 != g1;
                if (dp < BINS) begin
                    site_cnt[dp] = bump(site_cnt[dp], 1'b1);
                    het_cnt[dp] = bump(het_cnt[dp], r.het);
                end else begin
                    r.status = ST_TOO_DEEP;
                end
            end
            status_seen[r.status]++;
        end
        expected_q.push_back(r);
    endfunction

    task report(string msg);
        if (errors < 40) $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_result(logic [1:0] status, logic het, logic [CNT_W-1:0] sites,
                      logic [CNT_W-1:0] hets);
        result_t e;
        if (expected_q.size() == 0) begin
            report("result word arrived with nothing expected");
        end else begin
            e = expected_q.pop_front();
            checked++;
            if (status !== e.status)
                report($sformatf("word %0d site_status %0d, expected %0d", checked, status,
                                 e.status));
            if (het !== e.het)
                report($sformatf("word %0d is_het %0b, expected %0b", checked, het, e.het));
            if (sites !== e.sites)
                report($sformatf("word %0d bin_sites %0d, expected %0d", checked, sites,
                                 e.sites));
            if (hets !== e.hets)
                report($sformatf("word %0d bin_hets %0d, expected %0d", checked, hets, e.hets));
        end
    endtask
endclass

module testbench;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 64;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_operation = 1'b0;
    logic [DEPTH_W-1:0]    s_ref_depth = '0;
    logic [DEPTH_W-1:0]    s_alt_depth = '0;
    logic [BASE_W-1:0]     s_ref_base = '0;
    logic [BASE_W-1:0]     s_alt_base = '0;
    logic [BIN_IDX_W-1:0]  s_bin_index = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [1:0]            m_site_status;
    logic                  m_is_het;
    logic [CNT_W-1:0]      m_bin_sites;
    logic [CNT_W-1:0]      m_bin_hets;

    histogram_scoreboard board;
    bit calm = 1'b0;
    int words_sent = 0;
    int cycles = 0;

    random_read_het_histogram_top #(.DEPTH_BINS(BINS)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_ref_depth(s_ref_depth), .s_alt_depth(s_alt_depth),
        .s_ref_base(s_ref_base), .s_alt_base(s_alt_base), .s_bin_index(s_bin_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_site_status(m_site_status),
        .m_is_het(m_is_het), .m_bin_sites(m_bin_sites), .m_bin_hets(m_bin_hets)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles, board.pending());
            $display("testbench: done, errors");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 8);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_site_status, m_is_het, m_bin_sites, m_bin_hets);
    end

    function automatic word_t mk_site(int rd, int ad, int rb, int ab);
        word_t w;
        w.op = OP_SITE;
        w.rdep = DEPTH_W'(rd);
        w.adep = DEPTH_W'(ad);
        w.rbase = BASE_W'(rb);
        w.abase = BASE_W'(ab);
        w.bin = BIN_IDX_W'($urandom);
        return w;
    endfunction

    function automatic word_t mk_read(int b);
        word_t w;
        w = mk_site($urandom, $urandom, $urandom, $urandom);
        w.op = OP_READ;
        w.bin = BIN_IDX_W'(b);
        return w;
    endfunction

    function automatic word_t random_word();
        word_t w;
        int    pick;
        int    rd;
        int    ad;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            rd = 0;
            ad = 0;
        end else if (pick < 70) begin
            rd = $urandom_range(0, 30);
            ad = $urandom_range(0, 30);
        end else if (pick < 85) begin
            rd = $urandom_range(0, 1030);
            ad = $urandom_range(0, 1040 - rd);
        end else begin
            rd = $urandom;
            ad = $urandom;
        end
        w = mk_site(rd, ad, $urandom_range(0, 7), $urandom_range(0, 7));
        if ($urandom_range(0, 99) < 30) begin
            case ($urandom_range(0, 3))
                0: {w.rbase, w.abase} = {BASE_C, BASE_T};
                1: {w.rbase, w.abase} = {BASE_T, BASE_C};
                2: {w.rbase, w.abase} = {BASE_G, BASE_A};
                default: {w.rbase, w.abase} = {BASE_A, BASE_G};
            endcase
        end
        if ($urandom_range(0, 99) < 18) begin
            w.op = OP_READ;
            if ($urandom_range(0, 2) != 0) w.bin = BIN_IDX_W'($urandom_range(0, 63));
        end
        return w;
    endfunction

    task automatic send_word(input word_t w);
        @(negedge aclk);
        while (!calm && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= w.op;
        s_ref_depth <= w.rdep;
        s_alt_depth <= w.adep;
        s_ref_base <= w.rbase;
        s_alt_base <= w.abase;
        s_bin_index <= w.bin;
        do @(posedge aclk); while (!s_ready);
        board.note_input(w);
        words_sent++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        board.set_reg(idx, data);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input bit skip, input logic [GEN_W-1:0] seed, input int n);
        write_reg(CFG_SKIP_TRANS, CFG_DATA_W'(skip));
        write_reg(CFG_SEED, CFG_DATA_W'(seed));
        repeat (n) send_word(random_word());
        drain();
    endtask

    initial begin
        board = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset values of both registers are in force for this first part.
        send_word(mk_read(0));
        send_word(mk_read(1023));
        send_word(mk_site(0, 0, 0, 0));
        send_word(mk_site(1, 0, 0, 1));
        send_word(mk_site(0, 1, 2, 3));
        send_word(mk_site(5, 5, 1, 3));
        send_word(mk_site(1023, 0, 0, 0));
        send_word(mk_site(0, 1023, 3, 2));
        send_word(mk_site(512, 512, 0, 2));
        send_word(mk_site(20'hFFFFF, 20'hFFFFF, 7, 7));
        send_word(mk_site(3, 4, 4, 5));
        send_word(mk_site(6, 1, 6, 2));
        send_word(mk_read(1));
        send_word(mk_read(10));
        send_word(mk_read(1023));
        send_word(mk_read(7));
        drain();

        write_reg(CFG_SKIP_TRANS, CFG_DATA_W'(1));
        send_word(mk_site(3, 3, 1, 3));
        send_word(mk_site(3, 3, 3, 1));
        send_word(mk_site(3, 3, 2, 0));
        send_word(mk_site(3, 3, 0, 2));
        send_word(mk_site(0, 0, 1, 3));
        send_word(mk_site(2, 2, 0, 1));
        send_word(mk_site(2, 2, 5, 1));
        send_word(mk_site(600, 600, 2, 0));
        send_word(mk_read(4));
        send_word(mk_read(0));
        drain();

        run_phase(1'b0, '0, 90);
        calm = 1'b1;
        run_phase(1'b1, '1, 90);
        calm = 1'b0;
        run_phase(1'b0, GEN_W'({$urandom, $urandom}), 90);
        run_phase(1'b1, GEN_W'({$urandom, $urandom}), 90);
        run_phase(1'($urandom), GEN_W'({$urandom, $urandom}), 90);

        $display("testbench: covered %0d words, %0d results checked, %0d bin reads",
                 words_sent, board.checked, board.reads);
        $display("testbench: sites counted %0d, zero depth %0d, skipped %0d, too deep %0d",
                 board.status_seen[ST_COUNTED], board.status_seen[ST_ZERO_DEPTH],
                 board.status_seen[ST_TRANS_SKIP], board.status_seen[ST_TOO_DEEP]);
        if (board.errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule

// File: files.f
sv/rrhh_pkg.sv
sv/rrhh_lcg.sv
sv/rrhh_div.sv
sv/rrhh_datapath.sv
sv/rrhh_ctrl.sv
sv/random_read_het_histogram_top.sv
sv/rrhh_checker.sv
verif/testbench.sv
